// File: hw/rtl/scanline_span_depth_test_top_macros.svh
// Assertion macros shared by the checker.
`ifndef SCANLINE_SPAN_DEPTH_TEST_TOP_MACROS_SVH
`define SCANLINE_SPAN_DEPTH_TEST_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SSDT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssdt: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SSDT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssdt: next-cycle check failed");

`endif

// File: hw/rtl/ssdt_pkg.sv
`default_nettype none
package ssdt_pkg;

    localparam int LINE_WIDTH_DEF = 1024;

    localparam int OP_W    = 2;
    localparam int X_W     = 12;
    localparam int Z_W     = 32;
    localparam int COLOR_W = 24;
    localparam int INDEX_W = 10;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_SPAN  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // farthest depth, the most negative signed value
    localparam logic signed [Z_W-1:0] DEPTH_FAR = {1'b1, {(Z_W-1){1'b0}}};

endpackage
`default_nettype wire

// File: hw/rtl/scanline_span_depth_test_top.sv
// Clear row: one depth entry written per cycle after the transfer.
// Span: one read-compare-write per cycle for each covered pixel, through the depth
//   memory port; an empty span or an unknown op leaves the block in idle.
// Read pixel: memories read at the transfer; S_RESULT loads the output register once it is free.
// Reset: asynchronous, active low; then a clearing pass over every entry
//   of the depth line runs before the first item is taken.
`default_nettype none
module scanline_span_depth_test_top
    import ssdt_pkg::*;
#(
    parameter int LINE_WIDTH = LINE_WIDTH_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [OP_W-1:0]           operation,
    input  wire logic signed [X_W-1:0]     x_left,
    input  wire logic signed [X_W-1:0]     x_right,
    input  wire logic signed [Z_W-1:0]     z_start,
    input  wire logic signed [Z_W-1:0]     z_step,
    input  wire logic [COLOR_W-1:0]        span_color,
    input  wire logic [INDEX_W-1:0]        pixel_index,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [COLOR_W-1:0]             pixel_color,
    output logic signed [Z_W-1:0]          pixel_depth,
    output logic                           covered
);

    localparam int ADDR_W = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
    localparam int XS_W   = X_W + 1;
    localparam logic signed [XS_W-1:0] LAST_MAX = XS_W'(LINE_WIDTH - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(LINE_WIDTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SPAN,
        S_DRAIN,
        S_RESULT
    } state_t;

    function automatic logic signed [Z_W-1:0] sat_add(
        input logic signed [Z_W-1:0] a,
        input logic signed [Z_W-1:0] b
    );
        logic signed [Z_W:0] sum;
        sum = {a[Z_W-1], a} + {b[Z_W-1], b};
        if (sum[Z_W] != sum[Z_W-1])
            return sum[Z_W] ? {1'b1, {(Z_W-1){1'b0}}} : {1'b0, {(Z_W-1){1'b1}}};
        return sum[Z_W-1:0];
    endfunction

    logic signed [Z_W-1:0]   depth_mem [LINE_WIDTH];
    logic [COLOR_W-1:0]      color_mem [LINE_WIDTH];
    logic signed [Z_W-1:0]   depth_rdata;
    logic [COLOR_W-1:0]      color_rdata;

    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       x_reg, x_next;
    logic [ADDR_W-1:0]       last_reg, last_next;
    logic signed [Z_W-1:0]   z_reg, z_next;
    logic signed [Z_W-1:0]   step_reg, step_next;
    logic [COLOR_W-1:0]      color_reg, color_next;
    logic                    p_valid_reg, p_valid_next;
    logic [ADDR_W-1:0]       p_addr_reg, p_addr_next;
    logic signed [Z_W-1:0]   p_z_reg, p_z_next;
    logic                    range_reg, range_next;
    logic                    out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]      out_color_reg, out_color_next;
    logic signed [Z_W-1:0]   out_depth_reg, out_depth_next;
    logic                    out_cov_reg, out_cov_next;

    logic                    in_xfer;
    logic signed [XS_W-1:0]  xl_s, xr_m1, span_first, span_last;
    logic                    span_empty;
    logic [X_W-1:0]          idx_w;
    logic                    idx_in_range;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    win;
    logic                    dwe, cwe;
    logic [ADDR_W-1:0]       wr_addr;
    logic signed [Z_W-1:0]   wr_depth;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign pixel_color = out_color_reg;
    assign pixel_depth = out_depth_reg;
    assign covered     = out_cov_reg;

    assign xl_s       = {x_left[X_W-1], x_left};
    assign xr_m1      = {x_right[X_W-1], x_right} - XS_W'(1);
    assign span_first = (xl_s > 0) ? xl_s : '0;
    assign span_last  = (xr_m1 > LAST_MAX) ? LAST_MAX : xr_m1;
    assign span_empty = (span_first > span_last);

    assign idx_w        = {{(X_W-INDEX_W){1'b0}}, pixel_index};
    assign idx_in_range = (idx_w < X_W'(LINE_WIDTH));

    assign rd_en   = (state_reg == S_SPAN) || (in_xfer && operation == OP_READ);
    assign rd_addr = (state_reg == S_SPAN) ? x_reg : idx_w[ADDR_W-1:0];

    // strictly nearer than what is stored
    assign win = p_valid_reg && (p_z_reg > depth_rdata);

    assign dwe      = (state_reg == S_CLEAR) || win;
    assign cwe      = win;
    assign wr_addr  = (state_reg == S_CLEAR) ? x_reg : p_addr_reg;
    assign wr_depth = (state_reg == S_CLEAR) ? DEPTH_FAR : p_z_reg;

    always_ff @(posedge clk)
    begin
        if (dwe)
            depth_mem[wr_addr] <= wr_depth;
        if (rd_en)
            depth_rdata <= depth_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cwe)
            color_mem[p_addr_reg] <= color_reg;
        if (rd_en)
            color_rdata <= color_mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        last_next      = last_reg;
        z_next         = z_reg;
        step_next      = step_reg;
        color_next     = color_reg;
        p_valid_next   = 1'b0;
        p_addr_next    = p_addr_reg;
        p_z_next       = p_z_reg;
        range_next     = range_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_color_next = out_color_reg;
        out_depth_next = out_depth_reg;
        out_cov_next   = out_cov_reg;

        case (state_reg)
            S_CLEAR:
            begin
                x_next = x_reg + ADDR_W'(1);
                if (x_reg == ADDR_LAST)
                begin
                    x_next     = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    case (operation)
                        OP_CLEAR:
                        begin
                            x_next     = '0;
                            state_next = S_CLEAR;
                        end
                        OP_SPAN:
                        begin
                            x_next     = span_first[ADDR_W-1:0];
                            last_next  = span_last[ADDR_W-1:0];
                            z_next     = z_start;
                            step_next  = z_step;
                            color_next = span_color;
                            if (!span_empty)
                                state_next = S_SPAN;
                        end
                        OP_READ:
                        begin
                            range_next = idx_in_range;
                            state_next = S_RESULT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SPAN:
            begin
                p_valid_next = 1'b1;
                p_addr_next  = x_reg;
                p_z_next     = z_reg;
                z_next       = sat_add(z_reg, step_reg);
                x_next       = x_reg + ADDR_W'(1);
                if (x_reg == last_reg)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                // last pixel writes back this cycle
                state_next = S_IDLE;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (range_reg)
                    begin
                        out_color_next = color_rdata;
                        out_depth_next = depth_rdata;
                        out_cov_next   = (depth_rdata != DEPTH_FAR);
                    end
                    else
                    begin
                        out_color_next = '0;
                        out_depth_next = DEPTH_FAR;
                        out_cov_next   = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            x_reg         <= '0;
            last_reg      <= '0;
            z_reg         <= '0;
            step_reg      <= '0;
            color_reg     <= '0;
            p_valid_reg   <= 1'b0;
            p_addr_reg    <= '0;
            p_z_reg       <= '0;
            range_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_color_reg <= '0;
            out_depth_reg <= '0;
            out_cov_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            x_reg         <= x_next;
            last_reg      <= last_next;
            z_reg         <= z_next;
            step_reg      <= step_next;
            color_reg     <= color_next;
            p_valid_reg   <= p_valid_next;
            p_addr_reg    <= p_addr_next;
            p_z_reg       <= p_z_next;
            range_reg     <= range_next;
            out_valid_reg <= out_valid_next;
            out_color_reg <= out_color_next;
            out_depth_reg <= out_depth_next;
            out_cov_reg   <= out_cov_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/ssdt_checker.sv
`default_nettype none
`include "scanline_span_depth_test_top_macros.svh"
module ssdt_checker
    import ssdt_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic [OP_W-1:0]       operation,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic signed [Z_W-1:0] pixel_depth,
    input wire logic                  covered
);

    // a pending result stays offered
    `SSDT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // coverage flag tracks the stored depth
    `SSDT_ASSERT_NOW(a_cov_depth, out_valid, covered == (pixel_depth != DEPTH_FAR))

    // clear and read transfers take the block out of idle, so in_ready drops
    `SSDT_ASSERT_NEXT(a_busy_after,
        in_valid && in_ready && (operation == OP_CLEAR || operation == OP_READ),
        !in_ready)

endmodule

bind scanline_span_depth_test_top ssdt_checker u_ssdt_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_depth (pixel_depth),
    .covered     (covered)
);
`default_nettype wire

// File: verif/scanline_span_depth_test_checker.sv
`timescale 1ns / 1ps
module scanline_span_depth_test_checker
    import ssdt_pkg::*;
#(
    parameter int LINE_W = LINE_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic [OP_W-1:0]       operation,
    input  wire logic signed [X_W-1:0] x_left,
    input  wire logic signed [X_W-1:0] x_right,
    input  wire logic signed [Z_W-1:0] z_start,
    input  wire logic signed [Z_W-1:0] z_step,
    input  wire logic [COLOR_W-1:0]    span_color,
    input  wire logic [INDEX_W-1:0]    pixel_index,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [COLOR_W-1:0]    pixel_color,
    input  wire logic signed [Z_W-1:0] pixel_depth,
    input  wire logic                  covered,
    output int                         mismatches,
    output int                         reads_pending
);

    typedef struct packed {
        logic [COLOR_W-1:0]    color;
        logic signed [Z_W-1:0] depth;
        logic                  cov;
    } pixel_view_t;

    logic signed [Z_W-1:0] depth_row [LINE_W];
    logic [COLOR_W-1:0]    colour_row [LINE_W];
    pixel_view_t           read_queue [$];
    int                    fail_count = 0;

    function automatic logic signed [Z_W-1:0] depth_add_sat(
        input logic signed [Z_W-1:0] a,
        input logic signed [Z_W-1:0] b
    );
        longint s;
        s = longint'(a) + longint'(b);
        if (s > 64'sd2147483647)
            return {1'b0, {(Z_W-1){1'b1}}};
        if (s < -64'sd2147483648)
            return DEPTH_FAR;
        return s[Z_W-1:0];
    endfunction

    task automatic draw_span(
        input logic signed [X_W-1:0] xl,
        input logic signed [X_W-1:0] xr,
        input logic signed [Z_W-1:0] zs,
        input logic signed [Z_W-1:0] dz,
        input logic [COLOR_W-1:0]    col
    );
        int                    first;
        int                    last;
        logic signed [Z_W-1:0] z;
        first = (xl > 0) ? int'(xl) : 0;
        last  = int'(xr) - 1;
        if (last > LINE_W - 1)
            last = LINE_W - 1;
        z = zs;
        for (int x = first; x <= last; x++)
        begin
            // strictly nearer wins, equal depth keeps the old pixel
            if (z > depth_row[x])
            begin
                depth_row[x]  = z;
                colour_row[x] = col;
            end
            z = depth_add_sat(z, dz);
        end
    endtask

    always @(posedge clk)
    begin
        pixel_view_t got;
        pixel_view_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < LINE_W; i++)
            begin
                depth_row[i]  = DEPTH_FAR;
                colour_row[i] = '0;
            end
            read_queue.delete();
        end
        else
        begin
            // result side first: it always belongs to an older read
            if (out_valid && out_ready)
            begin
                got = '{color: pixel_color, depth: pixel_depth, cov: covered};
                if (read_queue.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result colour %h depth %h covered %b",
                             $time, pixel_color, pixel_depth, covered);
                end
                else
                begin
                    want = read_queue.pop_front();
                    if (got.color !== want.color)
                    begin
                        fail_count++;
                        $display("%0t: pixel_color expected %h actual %h",
                                 $time, want.color, got.color);
                    end
                    if (got.depth !== want.depth)
                    begin
                        fail_count++;
                        $display("%0t: pixel_depth expected %h actual %h",
                                 $time, want.depth, got.depth);
                    end
                    if (got.cov !== want.cov)
                    begin
                        fail_count++;
                        $display("%0t: covered expected %b actual %b",
                                 $time, want.cov, got.cov);
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                case (operation)
                    OP_CLEAR:
                        for (int i = 0; i < LINE_W; i++)
                            depth_row[i] = DEPTH_FAR;
                    OP_SPAN:
                        draw_span(x_left, x_right, z_start, z_step, span_color);
                    OP_READ:
                    begin
                        if (int'(pixel_index) < LINE_W)
                            want = '{color: colour_row[pixel_index],
                                     depth: depth_row[pixel_index],
                                     cov:   depth_row[pixel_index] != DEPTH_FAR};
                        else
                            want = '{color: '0, depth: DEPTH_FAR, cov: 1'b0};
                        read_queue = {read_queue, want};
                    end
                    default: ;
                endcase
            end
        end
        mismatches    <= fail_count;
        reads_pending <= read_queue.size();
    end

endmodule

// File: verif/tb_scanline_span_depth_test_top.sv
`timescale 1ns / 1ps
module tb_scanline_span_depth_test_top;
    import ssdt_pkg::*;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam int RANDOM_ITEMS = 560;
    localparam int CYCLE_LIMIT  = 2000000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [OP_W-1:0]       operation = OP_CLEAR;
    logic signed [X_W-1:0] x_left = '0;
    logic signed [X_W-1:0] x_right = '0;
    logic signed [Z_W-1:0] z_start = '0;
    logic signed [Z_W-1:0] z_step = '0;
    logic [COLOR_W-1:0]    span_color = '0;
    logic [INDEX_W-1:0]    pixel_index = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [COLOR_W-1:0]    pixel_color;
    logic signed [Z_W-1:0] pixel_depth;
    logic                  covered;

    int mismatches;
    int reads_pending;
    int cycle_count = 0;
    bit calm = 1'b0;

    always #5 clk = ~clk;

    scanline_span_depth_test_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .x_left      (x_left),
        .x_right     (x_right),
        .z_start     (z_start),
        .z_step      (z_step),
        .span_color  (span_color),
        .pixel_index (pixel_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_color (pixel_color),
        .pixel_depth (pixel_depth),
        .covered     (covered)
    );

    scanline_span_depth_test_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .x_left        (x_left),
        .x_right       (x_right),
        .z_start       (z_start),
        .z_step        (z_step),
        .span_color    (span_color),
        .pixel_index   (pixel_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_color   (pixel_color),
        .pixel_depth   (pixel_depth),
        .covered       (covered),
        .mismatches    (mismatches),
        .reads_pending (reads_pending)
    );

    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 22);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** scanline_span_depth_test_top: FAILED **");
            $finish;
        end
    end

    // one transfer on the input channel, with an occasional gap before it
    task automatic push_item(
        input logic [OP_W-1:0]    op,
        input int                 xl,
        input int                 xr,
        input logic [Z_W-1:0]     zs,
        input logic [Z_W-1:0]     dz,
        input logic [COLOR_W-1:0] col,
        input logic [INDEX_W-1:0] idx
    );
        if (!calm && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        x_left      <= X_W'(xl);
        x_right     <= X_W'(xr);
        z_start     <= zs;
        z_step      <= dz;
        span_color  <= col;
        pixel_index <= idx;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    initial
    begin
        int sel;
        int xl;
        int xr;
        int span_base;
        logic [Z_W-1:0] zs;
        logic [Z_W-1:0] dz;

        span_base = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // whole row first, so every colour entry is defined before any read
        push_item(OP_SPAN, -2048, 2047, 32'h0, 32'h0, 24'hFFFFFF, '0);
        push_item(OP_READ, 0, 0, 0, 0, 0, 10'd0);
        push_item(OP_READ, 0, 0, 0, 0, 0, 10'd1023);
        push_item(OP_READ, 0, 0, 0, 0, 0, 10'h2AA);
        push_item(OP_READ, 0, 0, 0, 0, 0, 10'h155);
        // saturation at the near end
        push_item(OP_SPAN, 100, 110, 32'h7FFF_FFF0, 32'h8, 24'h123456, '0);
        push_item(OP_READ, 0, 0, 0, 0, 0, 10'd100);
        push_item(OP_READ, 0, 0, 0, 0, 0, 10'd109);
        push_item(OP_SPAN, 1023, 1024, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h000000, '0);
        push_item(OP_READ, 0, 0, 0, 0, 0, 10'd1023);
        // empty spans
        push_item(OP_SPAN, 50, 50, 32'd1000, 32'd1, 24'hAAAAAA, '0);
        push_item(OP_SPAN, 2047, -2048, 32'd1000, 32'd1, 24'h555555, '0);
        push_item(OP_READ, 0, 0, 0, 0, 0, 10'd50);
        // equal depth does not overwrite
        push_item(OP_SPAN, 200, 210, 32'h0005_0000, 32'h0, 24'h0000FF, '0);
        push_item(OP_SPAN, 200, 210, 32'h0005_0000, 32'h0, 24'hFF0000, '0);
        push_item(OP_READ, 0, 0, 0, 0, 0, 10'd205);
        push_item(OP_NONE, 0, 2047, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFFFFFF, 10'd1);
        push_item(OP_CLEAR, 0, 0, 0, 0, 0, '0);
        push_item(OP_READ, 0, 0, 0, 0, 0, 10'd300);
        // farthest depth never wins; saturation at the far end
        push_item(OP_SPAN, 0, 16, DEPTH_FAR, 32'h0, 24'h00FF00, '0);
        push_item(OP_READ, 0, 0, 0, 0, 0, 10'd8);
        push_item(OP_SPAN, 20, 32, -32'sd100, 32'h8000_0000, 24'h0F0F0F, '0);
        push_item(OP_READ, 0, 0, 0, 0, 0, 10'd20);
        push_item(OP_READ, 0, 0, 0, 0, 0, 10'd21);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= 150 && n < 280);
            sel = $urandom_range(99);
            if (sel < 3)
                push_item(OP_CLEAR, 0, 0, 0, 0, 0, '0);
            else if (sel < 5)
                push_item(OP_NONE, int'($urandom_range(4095)), int'($urandom_range(4095)),
                          $urandom, $urandom, COLOR_W'($urandom), INDEX_W'($urandom));
            else if (sel < 50)
            begin
                sel = $urandom_range(99);
                if (sel < 3)
                begin
                    xl = -int'($urandom_range(5));
                    xr = 1024 + int'($urandom_range(1023));
                end
                else if (sel < 10)
                begin
                    xl = int'($urandom_range(4095)) - 2048;
                    xr = int'($urandom_range(4095)) - 2048;
                end
                else
                begin
                    xl = int'($urandom_range(1043)) - 20;
                    xr = xl + int'($urandom_range(48));
                end
                sel = $urandom_range(3);
                if (sel == 0)
                begin
                    zs = $urandom;
                    dz = $urandom;
                end
                else
                begin
                    zs = Z_W'(int'($urandom_range(2097151)) - 1048576);
                    dz = Z_W'(int'($urandom_range(8191)) - 4096);
                end
                span_base = (xl > 0) ? xl : 0;
                push_item(OP_SPAN, xl, xr, zs, dz, COLOR_W'($urandom), '0);
            end
            else if ($urandom_range(1))
                push_item(OP_READ, 0, 0, 0, 0, 0,
                          INDEX_W'(span_base + int'($urandom_range(63))));
            else
                push_item(OP_READ, 0, 0, 0, 0, 0, INDEX_W'($urandom));
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        while (reads_pending != 0) @(posedge clk);
        repeat (2 * LINE_WIDTH_DEF + 8) @(posedge clk);

        if (mismatches == 0 && reads_pending == 0)
            $display("** scanline_span_depth_test_top: PASSED **");
        else
            $display("** scanline_span_depth_test_top: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/ssdt_pkg.sv
hw/rtl/scanline_span_depth_test_top.sv
hw/rtl/ssdt_checker.sv
verif/scanline_span_depth_test_checker.sv
verif/tb_scanline_span_depth_test_top.sv
